// ----- rtl/mono_lcd_framebuffer_engine_defines.svh -----
// Assertion macros shared by the frame buffer engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MONO_LCD_FRAMEBUFFER_ENGINE_DEFINES_SVH
`define MONO_LCD_FRAMEBUFFER_ENGINE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MLFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlfb: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define MLFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlfb: next-cycle check failed");

`endif

// ----- rtl/mlfb_pkg.sv -----
// Shared types and constants of the monochrome LCD frame buffer engine.
// No dependencies.
package mlfb_pkg;

  // item kinds (in_tuser)
  localparam logic [2:0] KIND_PIXEL = 3'd0;
  localparam logic [2:0] KIND_RECT  = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_ARM   = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  // register indexes
  localparam int unsigned REG_AUTO_UPDATE = 0;

  // controller command bytes
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  localparam int unsigned ROWS = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECT,
    ST_TICK
  } mlfb_state_t;

  // refresh sequencer status for the current byte
  typedef struct packed {
    logic       pending;
    logic       is_data;
    logic       last;
    logic [2:0] page;
    logic [7:0] cmd_byte;
  } mlfb_seq_t;

endpackage

// ----- rtl/mono_lcd_framebuffer_engine.sv -----
// Monochrome page LCD frame buffer engine: top level.
// Depends on mlfb_pkg, mlfb_store, mlfb_seq and mono_lcd_framebuffer_engine_defines.svh.
// Usage:
//  - in_* channel takes drawing and refresh items; kind rides in in_tuser.
//    Pixel and rectangle items read-modify-write the column store, clear-all
//    blanks it, arm restarts the refresh sequence at byte 0.
//  - A tick item emits the next refresh byte on out_*: per page the command
//    bytes 0xB0|page, 0x00, 0x10, then one data byte per column. out_tuser is
//    the A0 level (1 = data), out_tlast flags the final byte of the refresh;
//    a tick with no refresh armed produces nothing.
//  - auto_update (APB register 0, reset 1) makes pixel/rectangle items arm.
// Sequencing:
//  - Clear, arm and unused kinds finish on acceptance. Pixel: read, then write back.
//  - Rectangle: read of the first clipped column, then one column per cycle through
//    the store's single read and write ports; empty rectangles skip the walk.
//  - Tick: store read when the tick is accepted, then the output register loads
//    from ST_TICK once it is empty or out_tready takes the byte held there.
//  - If out_tready stalls, the result waits in the output register and other
//    items are still taken; a new tick holds the input until it frees up.
// Reset (rst_n, synchronous): store reads as zero, no refresh armed, auto_update = 1.
module mono_lcd_framebuffer_engine #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] x_start, [11:7] y_start, [19:12] x_end, [25:20] y_end, [26] color
  input  logic [31:0] in_tdata,
  // [2:0] kind
  input  logic [2:0]  in_tuser,
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte
  output logic [7:0]  out_tdata,
  // [0] is_data
  output logic        out_tuser,
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "mono_lcd_framebuffer_engine_defines.svh"

  localparam int unsigned AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned CW = $clog2(COLUMNS + 1);
  localparam int unsigned RW = mlfb_pkg::ROWS;

  // ---------------- configuration ----------------
  logic auto_update_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // single register; reads at every address return it, writes decode only address 0
  assign cfg_prdata = {31'b0, auto_update_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_update_r <= 1'b1;
    end else if (cfg_wr && (cfg_paddr[1:0] == 2'(mlfb_pkg::REG_AUTO_UPDATE * 4))) begin
      auto_update_r <= cfg_pwdata[0];
    end
  end

  // ---------------- input decode ----------------
  logic [2:0] kind;
  logic [6:0] x_start;
  logic [4:0] y_start;
  logic [7:0] x_end;
  logic [5:0] y_end;
  logic       color;
  logic       in_acc;

  assign kind    = in_tuser;
  assign x_start = in_tdata[6:0];
  assign y_start = in_tdata[11:7];
  assign x_end   = in_tdata[19:12];
  assign y_end   = in_tdata[25:20];
  assign color   = in_tdata[26];
  assign in_acc  = in_tvalid && in_tready;

  // a pixel is a 1x1 rectangle; bounds clip to the store
  logic [8:0]    xs9, xe9, xb9;
  logic [5:0]    ye6, yb6;
  logic          is_draw, rect_nonempty;
  logic [RW-1:0] mask_hi, mask_lo, row_mask;

  always_comb begin
    is_draw = (kind == mlfb_pkg::KIND_PIXEL) || (kind == mlfb_pkg::KIND_RECT);
    xs9     = {2'b0, x_start};
    if (kind == mlfb_pkg::KIND_PIXEL) begin
      xe9 = xs9 + 9'd1;
      ye6 = {1'b0, y_start} + 6'd1;
    end else begin
      xe9 = {1'b0, x_end};
      ye6 = y_end;
    end
    xb9 = (xe9 < 9'(COLUMNS)) ? xe9 : 9'(COLUMNS);
    yb6 = (ye6 < 6'(RW)) ? ye6 : 6'(RW);
    rect_nonempty = (xs9 < xb9);
    mask_hi  = (yb6 == 6'(RW)) ? '1 : ((RW'(1) << yb6[4:0]) - RW'(1));
    mask_lo  = ~((RW'(1) << y_start) - RW'(1));
    row_mask = mask_hi & mask_lo;
  end

  // ---------------- state and datapath regs ----------------
  mlfb_pkg::mlfb_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [AW-1:0]         rd_col_r;
  logic [CW-1:0]         nxt_col_r, end_col_r;
  logic [RW-1:0]         mask_r;
  logic                  color_r;
  mlfb_pkg::mlfb_seq_t   tk_r;
  logic [7:0]            out_byte_r;
  logic                  out_data_r, out_last_r;

  // control decode
  logic          mem_re, mem_we, clr_all, seq_arm, seq_step;
  logic          load_rect, load_tick, load_out, rect_more;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [RW-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0] seq_col;
  mlfb_pkg::mlfb_seq_t seq_st;

  assign rect_more = (nxt_col_r < end_col_r);
  assign in_tready = (state_r == mlfb_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlfb_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_draw && rect_nonempty) begin
            state_nxt = mlfb_pkg::ST_RECT;
          end else if ((kind == mlfb_pkg::KIND_TICK) && seq_st.pending) begin
            state_nxt = mlfb_pkg::ST_TICK;
          end
        end
      end
      mlfb_pkg::ST_RECT: begin
        if (!rect_more) begin
          state_nxt = mlfb_pkg::ST_IDLE;
        end
      end
      mlfb_pkg::ST_TICK: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = mlfb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mlfb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = rd_col_r;
    mem_wdata = color_r ? (mem_rdata | mask_r) : (mem_rdata & ~mask_r);
    clr_all   = 1'b0;
    seq_arm   = 1'b0;
    seq_step  = 1'b0;
    load_rect = 1'b0;
    load_tick = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      mlfb_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kind) inside
            mlfb_pkg::KIND_PIXEL, mlfb_pkg::KIND_RECT: begin
              seq_arm = auto_update_r;
              if (rect_nonempty) begin
                load_rect = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = AW'(xs9);
              end
            end
            mlfb_pkg::KIND_CLEAR: begin
              clr_all = 1'b1;
              seq_arm = 1'b1;
            end
            mlfb_pkg::KIND_ARM: begin
              seq_arm = 1'b1;
            end
            mlfb_pkg::KIND_TICK: begin
              if (seq_st.pending) begin
                seq_step  = 1'b1;
                load_tick = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = seq_col;
              end
            end
            default: ;
          endcase
        end
      end
      mlfb_pkg::ST_RECT: begin
        // write back column rd_col_r while fetching the next one
        mem_we = 1'b1;
        if (rect_more) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(nxt_col_r);
        end
      end
      mlfb_pkg::ST_TICK: begin
        load_out = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlfb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (load_rect) begin
      rd_col_r  <= AW'(xs9);
      nxt_col_r <= CW'(xs9 + 9'd1);
      end_col_r <= CW'(xb9);
      mask_r    <= row_mask;
      color_r   <= color;
    end else if ((state_r == mlfb_pkg::ST_RECT) && rect_more) begin
      rd_col_r  <= AW'(nxt_col_r);
      nxt_col_r <= nxt_col_r + CW'(1);
    end
    if (load_tick) begin
      tk_r <= seq_st;
    end
    if (load_out) begin
      // pages past row 31 shift everything out and read zero
      out_byte_r <= tk_r.is_data ? 8'(mem_rdata >> {tk_r.page, 3'b000}) : tk_r.cmd_byte;
      out_data_r <= tk_r.is_data;
      out_last_r <= tk_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------- submodules ----------------
  mlfb_store #(
    .DEPTH (COLUMNS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (clr_all),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  mlfb_seq #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .AW      (AW)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .arm    (seq_arm),
    .step   (seq_step),
    .col    (seq_col),
    .status (seq_st)
  );

  // ---------------- assertions ----------------
  // rectangle walk never reads the column it is writing back
  `MLFB_ASSERT_SAME(a_no_rw_collide, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)
  // an armed tick always goes to the output stage
  `MLFB_ASSERT_NEXT(a_tick_to_out, clk, rst_n, load_tick, state_r == mlfb_pkg::ST_TICK)
  // emitting the last byte disarms the refresh
  `MLFB_ASSERT_NEXT(a_last_disarms, clk, rst_n, load_tick && seq_st.last, !seq_st.pending)
  // store writes only happen during the column walk
  `MLFB_ASSERT_SAME(a_write_in_walk, clk, rst_n, mem_we, state_r == mlfb_pkg::ST_RECT)

endmodule

// ----- rtl/mlfb_store.sv -----
// Column store: one 32-bit word per column, synchronous (registered) read.
// Per-entry valid bits give zero reset and a clear of all columns together. Uses mlfb_pkg.
module mlfb_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [mlfb_pkg::ROWS-1:0]  rdata,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [mlfb_pkg::ROWS-1:0]  wdata
);

  logic [mlfb_pkg::ROWS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld_r;
  logic [mlfb_pkg::ROWS-1:0] q_r;
  logic                      q_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (clear) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        q_vld_r <= vld_r[raddr];
      end
    end
  end

  // never-written columns read as blank
  assign rdata = q_vld_r ? q_r : '0;

endmodule

// ----- rtl/mlfb_seq.sv -----
// Refresh byte sequencer: page/slot position and command byte for each step.
// Uses mlfb_pkg.
module mlfb_seq #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 4,
  parameter int unsigned AW      = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                arm,
  input  logic                step,
  output logic [AW-1:0]       col,
  output mlfb_pkg::mlfb_seq_t status
);

  localparam int unsigned PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned SW       = $clog2(COLUMNS + 3);
  localparam logic [SW-1:0] SLOT_LAST = SW'(COLUMNS + 2);
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);

  logic [PW-1:0] page_r, page_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          pending_r, pending_nxt;
  logic          last;

  assign last = (page_r == PAGE_LAST) && (slot_r == SLOT_LAST);

  always_comb begin
    page_nxt    = page_r;
    slot_nxt    = slot_r;
    pending_nxt = pending_r;
    if (arm) begin
      page_nxt    = '0;
      slot_nxt    = '0;
      pending_nxt = 1'b1;
    end else if (step) begin
      if (last) begin
        page_nxt    = '0;
        slot_nxt    = '0;
        pending_nxt = 1'b0;
      end else if (slot_r == SLOT_LAST) begin
        slot_nxt = '0;
        page_nxt = page_r + PW'(1);
      end else begin
        slot_nxt = slot_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r    <= '0;
      slot_r    <= '0;
      pending_r <= 1'b0;
    end else begin
      page_r    <= page_nxt;
      slot_r    <= slot_nxt;
      pending_r <= pending_nxt;
    end
  end

  // data slots start after the three command bytes
  assign col = AW'(slot_r - SW'(3));

  always_comb begin
    status.pending = pending_r;
    status.is_data = (slot_r >= SW'(3));
    status.last    = last;
    status.page    = 3'(page_r);
    case (slot_r)
      SW'(0):  status.cmd_byte = mlfb_pkg::CMD_PAGE | {5'b0, 3'(page_r)};
      SW'(1):  status.cmd_byte = mlfb_pkg::CMD_COL_LO;
      SW'(2):  status.cmd_byte = mlfb_pkg::CMD_COL_HI;
      default: status.cmd_byte = 8'h00;
    endcase
  end

endmodule
